// ===== rtl/nns_pkg.sv =====
// Shared types and constants for the nearest-neighbour square scaler.
package nns_pkg;

  // Operation codes carried in the input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 2;
  localparam logic [1:0]  CFG_SRC_SIZE    = 2'd0;
  localparam logic [1:0]  CFG_DST_SIZE    = 2'd1;
  localparam logic [1:0]  CFG_INVERT_MODE = 2'd2;
  localparam int          CFG_DATA_W      = 9;

  // Register reset values
  localparam logic [8:0]  SRC_SIZE_RST = 9'd64;
  localparam logic [8:0]  DST_SIZE_RST = 9'd64;

  // Divider: quotient below 512, so nine restoring steps suffice
  localparam int          QUO_W     = 9;
  localparam int          PROD_W    = 17;
  localparam int          CNT_W     = 4;
  localparam logic [3:0]  DIV_LAST  = 4'(QUO_W - 1);

  // Decoupling queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Input beat
  typedef struct packed {
    logic        operation;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] pixel_in;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [15:0] pixel_out;
    logic        out_of_range;
  } out_item_t;

  // Classification made by the front end
  typedef enum logic [1:0] {
    K_WRITE,
    K_READ,
    K_OOR
  } item_kind_t;

  // Entry of the queue between front and back
  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] pixel;
  } q_entry_t;

  // Live configuration seen by the back end
  typedef struct packed {
    logic [8:0] src_eff;
    logic [8:0] dst_size;
    logic       invert_mode;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_READ,
    B_OUT
  } back_state_t;

endpackage

// ===== rtl/nns_queue.sv =====
// Short FIFO that decouples the front end from the back end.
module nns_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nns_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output nns_pkg::q_entry_t rdata
);

  nns_pkg::q_entry_t                   entry_r [nns_pkg::Q_DEPTH];
  logic [nns_pkg::Q_PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [nns_pkg::Q_PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [nns_pkg::Q_CNT_W-1:0]         count_r, count_nxt;

  assign full      = (count_r == nns_pkg::Q_CNT_W'(nns_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nns_pkg::Q_CNT_W'(nns_pkg::Q_DEPTH))
    else $error("queue count above depth");

endmodule

// ===== rtl/nns_front.sv =====
// Front end: configuration registers, input acceptance and item classification.
module nns_front #(
  parameter int MAX_DIM = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  nns_pkg::in_item_t                   in_data,
  input  logic                                q_full,
  output logic                                q_push,
  output nns_pkg::q_entry_t                   q_wdata,
  output nns_pkg::cfg_t                       cfg
);

  logic [8:0] src_size_r;
  logic [8:0] dst_size_r;
  logic       invert_mode_r;
  logic [8:0] src_eff;
  logic       accept;
  logic       wr_inside;
  logic       rd_outside;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_size_r    <= nns_pkg::SRC_SIZE_RST;
      dst_size_r    <= nns_pkg::DST_SIZE_RST;
      invert_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nns_pkg::CFG_SRC_SIZE:    src_size_r    <= cfg_data;
        nns_pkg::CFG_DST_SIZE:    dst_size_r    <= cfg_data;
        nns_pkg::CFG_INVERT_MODE: invert_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Source size saturates at the store dimension
  assign src_eff = (int'(src_size_r) > MAX_DIM) ? 9'(MAX_DIM) : src_size_r;

  assign cfg.src_eff     = src_eff;
  assign cfg.dst_size    = dst_size_r;
  assign cfg.invert_mode = invert_mode_r;

  // Classify the beat: clipped writes are dropped here
  assign in_stall   = q_full;
  assign accept     = in_valid && !in_stall;
  assign wr_inside  = ({1'b0, in_data.col} < src_eff) && ({1'b0, in_data.row} < src_eff);
  assign rd_outside = ({1'b0, in_data.col} >= dst_size_r) ||
                      ({1'b0, in_data.row} >= dst_size_r);

  always_comb begin
    q_wdata.col   = in_data.col;
    q_wdata.row   = in_data.row;
    q_wdata.pixel = in_data.pixel_in;
    if (in_data.operation == nns_pkg::OP_WRITE) begin
      q_wdata.kind = nns_pkg::K_WRITE;
      q_push       = accept && wr_inside;
    end else begin
      q_wdata.kind = rd_outside ? nns_pkg::K_OOR : nns_pkg::K_READ;
      q_push       = accept;
    end
  end

endmodule

// ===== rtl/nns_back.sv =====
// Back end: scale arithmetic, frame store access and result register.
module nns_back #(
  parameter int MAX_DIM = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nns_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  nns_pkg::q_entry_t q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output nns_pkg::out_item_t out_data
);

  localparam int CW        = $clog2(MAX_DIM);
  localparam int AW        = 2 * CW;
  // Row and column each get CW address bits
  localparam int MEM_DEPTH = 1 << AW;

  nns_pkg::back_state_t        state_r, state_nxt;
  logic [nns_pkg::CNT_W-1:0]   cnt_r;

  // Lane 0 works on the column, lane 1 on the row
  logic [7:0]                  coord_r [2];
  logic [8:0]                  rem_r   [2];
  logic [8:0]                  low_r   [2];
  logic [nns_pkg::QUO_W-1:0]   quo_r   [2];
  logic [nns_pkg::PROD_W-1:0]  prod    [2];
  logic [9:0]                  trial   [2];
  logic                        ge      [2];

  logic [15:0]                 frame_store [MEM_DEPTH];
  logic [15:0]                 rd_data_r;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  logic                        out_valid_r;
  nns_pkg::out_item_t          out_data_r;
  logic                        slot_free;

  logic mem_wr, mem_rd, latch_coord, mul_en, div_en, load_out, load_oor;

  assign slot_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nns_pkg::B_IDLE: begin
        if (q_valid && q_entry.kind == nns_pkg::K_READ) begin
          state_nxt = nns_pkg::B_MUL;
        end
      end
      nns_pkg::B_MUL:  state_nxt = nns_pkg::B_DIV;
      nns_pkg::B_DIV: begin
        if (cnt_r == nns_pkg::DIV_LAST) begin
          state_nxt = nns_pkg::B_READ;
        end
      end
      nns_pkg::B_READ: state_nxt = nns_pkg::B_OUT;
      nns_pkg::B_OUT: begin
        if (slot_free) begin
          state_nxt = nns_pkg::B_IDLE;
        end
      end
      default:         state_nxt = nns_pkg::B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop       = 1'b0;
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;
    latch_coord = 1'b0;
    mul_en      = 1'b0;
    div_en      = 1'b0;
    load_out    = 1'b0;
    load_oor    = 1'b0;
    unique case (state_r)
      nns_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_entry.kind)
            nns_pkg::K_WRITE: begin
              q_pop  = 1'b1;
              mem_wr = 1'b1;
            end
            nns_pkg::K_READ: begin
              q_pop       = 1'b1;
              latch_coord = 1'b1;
            end
            nns_pkg::K_OOR: begin
              q_pop    = slot_free;
              load_oor = slot_free;
            end
            default: ;
          endcase
        end
      end
      nns_pkg::B_MUL:  mul_en   = 1'b1;
      nns_pkg::B_DIV:  div_en   = 1'b1;
      nns_pkg::B_READ: mem_rd   = 1'b1;
      nns_pkg::B_OUT:  load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nns_pkg::B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_en) begin
        cnt_r <= '0;
      end else if (div_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Product and one restoring divide step per lane
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod[i]  = nns_pkg::PROD_W'(coord_r[i]) * nns_pkg::PROD_W'(cfg.src_eff);
      trial[i] = {rem_r[i], low_r[i][8]};
      ge[i]    = (trial[i] >= {1'b0, cfg.dst_size});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (mul_en) begin
        // quotient fits nine bits, so the top product bits start the remainder
        rem_r[i] <= {1'b0, prod[i][16:9]};
        low_r[i] <= prod[i][8:0];
        quo_r[i] <= '0;
      end else if (div_en) begin
        rem_r[i] <= ge[i] ? 9'(trial[i] - {1'b0, cfg.dst_size}) : trial[i][8:0];
        low_r[i] <= {low_r[i][7:0], 1'b0};
        quo_r[i] <= {quo_r[i][nns_pkg::QUO_W-2:0], ge[i]};
      end
    end
    if (latch_coord) begin
      coord_r[0] <= q_entry.col;
      coord_r[1] <= q_entry.row;
    end
  end

  // Frame store, row-major
  assign wr_addr = {CW'(q_entry.row), CW'(q_entry.col)};
  assign rd_addr = {CW'(quo_r[1]), CW'(quo_r[0])};

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      frame_store[wr_addr] <= q_entry.pixel;
    end
    if (mem_rd) begin
      rd_data_r <= frame_store[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out || load_oor) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_oor) begin
      out_data_r.pixel_out    <= '0;
      out_data_r.out_of_range <= 1'b1;
    end else if (load_out) begin
      out_data_r.pixel_out    <= cfg.invert_mode ? ~rd_data_r : rd_data_r;
      out_data_r.out_of_range <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_of_range |-> out_data_r.pixel_out == '0)
    else $error("out-of-range result carries a pixel");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out || load_oor) |-> slot_free)
    else $error("result loaded over an unaccepted beat");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nns_pkg::B_DIV |-> cnt_r <= nns_pkg::DIV_LAST)
    else $error("divide step count overran");

  a_read_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nns_pkg::B_READ |-> $past(state_r) == nns_pkg::B_DIV)
    else $error("store read without a finished divide");

endmodule

// ===== rtl/nearest_neighbor_square_scaler.sv =====
// Top level of the square RGB565 nearest-neighbour scaler.
//
// Input channel (in_valid / in_stall / in_data): a beat is taken when valid
// is high and stall is low. A write beat stores pixel_in at (row, col) of the
// frame store; writes outside the source size are dropped with no result.
// A read beat returns one result beat holding the source pixel at
// (row, col) * src_size / dst_size, inverted when invert mode is set, or
// out_of_range with a zero pixel when the coordinate lies outside dst_size.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready and must be written only while the block is idle.
// Writes and out-of-range reads run at one beat per cycle while the back end
// is idle and, for out-of-range reads, the result slot is free. An in-range
// read holds the back end through queue pop, multiply, nine restoring divide
// steps, frame store read and result load. The two-entry queue lets new beats
// in while the back end works. When the receiver stalls, the result register
// holds its beat and the back end waits; the queue then fills and in_stall
// rises. Reset clears the queue, the sequencer and the result valid flag and
// sets src_size and dst_size to 64, invert mode off; the frame store is not
// cleared.
module nearest_neighbor_square_scaler #(
  parameter int MAX_DIM = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nns_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nns_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data
);

  nns_pkg::cfg_t     cfg;
  nns_pkg::q_entry_t q_wdata;
  nns_pkg::q_entry_t q_rdata;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;

  // Acceptance and classification
  nns_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .cfg       (cfg)
  );

  // Decoupling queue
  nns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  // Arithmetic, store and result
  nns_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_nearest_neighbor_square_scaler.sv =====
// Self-checking testbench for the nearest-neighbour square scaler.
module tb_nearest_neighbor_square_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index past the end of the list: a write there must do nothing
  localparam logic [1:0]  CFG_SPARE     = 2'd3;
  localparam int unsigned GRID          = 256;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 80;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic [1:0] idx;
    logic [8:0] val;
  } reg_write_t;

  // Mirror of the frame store and registers; predicts each read's result beat
  class scaler_scoreboard;
    logic [15:0] frame_copy [0:GRID*GRID-1];
    bit          written    [0:GRID*GRID-1];
    logic [8:0]  src_size = nns_pkg::SRC_SIZE_RST;
    logic [8:0]  dst_size = nns_pkg::DST_SIZE_RST;
    logic        invert   = 1'b0;
    nns_pkg::out_item_t pixels_due [$];
    int unsigned errors   = 0;

    function int unsigned src_eff();
      return (src_size > GRID) ? GRID : src_size;
    endfunction

    // Destination coordinate to source coordinate
    function int unsigned scale(int unsigned c);
      return c * src_eff() / dst_size;
    endfunction

    function bit outside_dst(int unsigned col, int unsigned row);
      return (col >= dst_size) || (row >= dst_size);
    endfunction

    // True when a read here touches nothing that is still unwritten
    function bit read_safe(int unsigned col, int unsigned row);
      if (outside_dst(col, row))
        return 1'b1;
      return written[scale(row) * GRID + scale(col)];
    endfunction

    function void apply_cfg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        nns_pkg::CFG_SRC_SIZE:    src_size = val;
        nns_pkg::CFG_DST_SIZE:    dst_size = val;
        nns_pkg::CFG_INVERT_MODE: invert   = val[0];
        default: ;
      endcase
    endfunction

    function void note_input(nns_pkg::in_item_t beat);
      int unsigned        se;
      int unsigned        addr;
      nns_pkg::out_item_t res;
      se = src_eff();
      if (beat.operation == nns_pkg::OP_WRITE) begin
        // clipped writes vanish
        if (beat.col < se && beat.row < se) begin
          addr             = beat.row * GRID + beat.col;
          frame_copy[addr] = beat.pixel_in;
          written[addr]    = 1'b1;
        end
        return;
      end
      if (outside_dst(beat.col, beat.row)) begin
        res.pixel_out    = '0;
        res.out_of_range = 1'b1;
      end else begin
        addr             = scale(beat.row) * GRID + scale(beat.col);
        res.pixel_out    = frame_copy[addr] ^ {16{invert}};
        res.out_of_range = 1'b0;
      end
      pixels_due.push_back(res);
    endfunction

    function void check_result(nns_pkg::out_item_t got);
      nns_pkg::out_item_t want;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual pixel %h oor %b",
                 $time, got.pixel_out, got.out_of_range);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0t: pixel_out expected %h actual %h",
                 $time, want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $display("%0t: out_of_range expected %b actual %b",
                 $time, want.out_of_range, got.out_of_range);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  nns_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  nns_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  scaler_scoreboard sb;
  reg_write_t       reg_writes [$];
  bit               tx_burst     = 1'b0;
  bit               rx_burst     = 1'b0;
  bit               hold_request = 1'b0;

  nearest_neighbor_square_scaler #(
    .MAX_DIM(GRID)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run-away guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("nearest_neighbor_square_scaler regression: fail");
    $finish;
  end

  // Half the beats go without a gap, the rest after a random wait
  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned hold;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold         = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = rx_burst ? 0 : draw_wait();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic drive_beat(nns_pkg::in_item_t beat);
    int unsigned gap;
    gap = tx_burst ? 0 : draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_input(beat);
  endtask

  task automatic drive_write(int unsigned col, int unsigned row, logic [15:0] pix);
    nns_pkg::in_item_t beat;
    beat.operation = nns_pkg::OP_WRITE;
    beat.col       = 8'(col);
    beat.row       = 8'(row);
    beat.pixel_in  = pix;
    drive_beat(beat);
  endtask

  // A read whose source entry is still blank gets that entry written first
  task automatic issue_read(int unsigned col, int unsigned row);
    nns_pkg::in_item_t beat;
    if (!sb.read_safe(col, row))
      drive_write(sb.scale(col), sb.scale(row), 16'($urandom()));
    beat.operation = nns_pkg::OP_READ;
    beat.col       = 8'(col);
    beat.row       = 8'(row);
    beat.pixel_in  = 16'($urandom());
    drive_beat(beat);
  endtask

  // Drop valid, let every result come home, then let trailing writes settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_reg(logic [1:0] idx, logic [8:0] val);
    reg_writes.push_back('{idx: idx, val: val});
  endtask

  // Write the queued registers back to back once the block is idle
  task automatic flush_regs();
    reg_write_t w;
    wait_idle();
    cfg_valid <= 1'b1;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_index <= w.idx;
      cfg_data  <= w.val;
      do @(posedge clk); while (!cfg_ready);
      sb.apply_cfg(w.idx, w.val);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_checks();
    // reset sizes: corners, clipping and out-of-range reads
    drive_write(0, 0, 16'hFFFF);
    drive_write(63, 63, 16'h0000);
    drive_write(64, 0, 16'h1234);
    drive_write(0, 64, 16'h4321);
    drive_write(7, 5, 16'hA5A5);
    issue_read(0, 0);
    issue_read(63, 63);
    issue_read(7, 5);
    issue_read(64, 0);
    issue_read(255, 255);
    // spare index is inert; invert keeps only its low bit
    queue_reg(CFG_SPARE, 9'h1FF);
    queue_reg(nns_pkg::CFG_INVERT_MODE, 9'h1FF);
    flush_regs();
    issue_read(7, 5);
    issue_read(0, 64);
    queue_reg(nns_pkg::CFG_INVERT_MODE, 9'h1FE);
    flush_regs();
    issue_read(63, 63);
    // zero destination: nothing is in range
    queue_reg(nns_pkg::CFG_DST_SIZE, 9'd0);
    flush_regs();
    issue_read(0, 0);
    // zero source: writes dropped, reads land on the origin
    queue_reg(nns_pkg::CFG_DST_SIZE, 9'd64);
    queue_reg(nns_pkg::CFG_SRC_SIZE, 9'd0);
    flush_regs();
    drive_write(1, 1, 16'hBEEF);
    issue_read(40, 50);
    // oversize source saturates at the grid
    queue_reg(nns_pkg::CFG_SRC_SIZE, 9'h1FF);
    queue_reg(nns_pkg::CFG_DST_SIZE, 9'd256);
    flush_regs();
    drive_write(255, 255, 16'h8000);
    drive_write(128, 0, 16'h7FFF);
    issue_read(255, 255);
    issue_read(128, 0);
  endtask

  task automatic random_item(inout int unsigned tally);
    int unsigned pick;
    int unsigned se;
    int unsigned lim;
    int unsigned col;
    int unsigned row;
    pick = $urandom_range(0, 99);
    se   = sb.src_eff();
    lim  = (sb.dst_size > GRID) ? GRID : sb.dst_size;
    if (pick < 45) begin
      if (se > 0) begin
        col = $urandom_range(0, se - 1);
        row = $urandom_range(0, se - 1);
        tally++;
      end else begin
        col = $urandom_range(0, 255);
        row = $urandom_range(0, 255);
      end
      drive_write(col, row, 16'($urandom()));
    end else if (pick < 93) begin
      if (lim > 0) begin
        col = $urandom_range(0, lim - 1);
        row = $urandom_range(0, lim - 1);
      end else begin
        col = $urandom_range(0, 255);
        row = $urandom_range(0, 255);
      end
      issue_read(col, row);
      tally++;
    end else begin
      // stray coordinates anywhere on the grid
      col = $urandom_range(0, 255);
      row = $urandom_range(0, 255);
      if ($urandom_range(0, 1) != 0)
        drive_write(col, row, 16'($urandom()));
      else
        issue_read(col, row);
    end
  endtask

  task automatic run_phase(int unsigned src, int unsigned dst, int unsigned inv,
                           bit long_hold);
    int unsigned tally;
    queue_reg(nns_pkg::CFG_SRC_SIZE, 9'(src));
    queue_reg(nns_pkg::CFG_DST_SIZE, 9'(dst));
    queue_reg(nns_pkg::CFG_INVERT_MODE, 9'(inv));
    flush_regs();
    tx_burst = long_hold || ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    tally    = 0;
    while (tally < PHASE_ITEMS) begin
      if (long_hold && tally == PHASE_ITEMS / 2)
        hold_request = 1'b1;
      random_item(tally);
    end
  endtask

  initial begin
    int unsigned k;
    sb = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    directed_checks();
    run_phase(8, 8, 0, 1'b0);
    run_phase(8, 24, 1, 1'b1);
    run_phase(16, 5, 0, 1'b0);
    run_phase(256, 256, 0, 1'b0);
    run_phase(511, 200, 1, 1'b0);
    run_phase(1, 1, 0, 1'b0);
    run_phase(0, 37, 1, 1'b1);
    run_phase(3, 0, 0, 1'b0);
    run_phase(256, 1, 1, 1'b0);
    run_phase(1, 256, 0, 1'b0);
    run_phase(12, 300, 1, 1'b0);
    run_phase(100, 77, 0, 1'b0);
    for (k = 0; k < 8; k++) begin
      run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24),
                $urandom_range(0, 511), ($urandom_range(0, 3) == 0));
    end
    wait_idle();
    if (sb.errors == 0)
      $display("nearest_neighbor_square_scaler regression: pass");
    else
      $display("nearest_neighbor_square_scaler regression: fail");
    $finish;
  end

endmodule
